>>> hdl/apr_pkg.sv
// Shared types, constants and defaults for the average pooling requantizer.
`default_nettype none

package apr_pkg;

   localparam int DefInWidth  = 32;
   localparam int DefInHeight = 32;
   localparam int DefChannels = 16;
   localparam int DefStrideX  = 2;
   localparam int DefStrideY  = 2;

   // Signed window coordinate: 31 * 16 + 31 still fits with room for negative pads.
   localparam int CoordW    = 12;
   // Largest window is 31 x 31 bytes of 255.
   localparam int SumW      = 18;
   localparam int ProdW     = SumW + 1 + 32;
   localparam int DivW      = 50;
   localparam int DsrW      = 10;
   localparam int ValW      = 52;
   localparam int ByteMax   = 255;
   localparam int CsrDataW  = 32;
   localparam int CsrIndexW = 3;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_REQUANT_ENABLE,
      CSR_SCALE,
      CSR_SHIFT,
      CSR_OFFSET,
      CSR_KERNEL_WIDTH,
      CSR_KERNEL_HEIGHT,
      CSR_PAD_TOP,
      CSR_PAD_LEFT
   } csr_index_type;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_COMPUTE = 1'b1
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] row;
      logic [4:0] col;
      logic [3:0] channel;
      logic [7:0] pixel;
   } req_word_type;

   typedef struct packed {
      logic [7:0] result_value;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_BASE,
      ST_ADDR,
      ST_WRITE,
      ST_SCAN,
      ST_DRAIN,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

>>> hdl/apr_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
`default_nettype none

interface apr_stream_if #(
   parameter type data_type = logic
);
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/apr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module apr_div #(
   parameter int DIVIDEND_W = apr_pkg::DivW,
   parameter int DIVISOR_W  = apr_pkg::DsrW
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [DIVIDEND_W-1:0]  dividend,
   input  wire logic [DIVISOR_W-1:0]   divisor,
   output logic      [DIVIDEND_W-1:0]  quotient,
   output apr_pkg::div_status_type     status
);

   localparam int CntW = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff      = rem_shift - {1'b0, dsr_ff};
   assign fits      = ~diff[DIVISOR_W];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CntW'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift the next dividend bit in, keep the quotient bit in its place
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < dsr_ff)
      else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

>>> hdl/avg_pool_requant_u8_core.sv
// Average pooling over a stored uint8 HWC map with optional requantization.
//
//  channel  dir  word               handshake
//  req_if   in   op,row,col,ch,pix  valid/ready, ready only while idle
//  rsp_if   out  result_value       valid/ready, one registered output word
//  csr_*    in   index, data        write enable, no back-pressure
//
// A compute reads every window byte inside the image: the store has one
// read port, so the window is read one byte per cycle, and the divider yields
// one quotient bit per cycle over 50 bits. A finished word waits in the output
// register while the next word is accepted. Reset is synchronous; the image
// store is not cleared and holds garbage until written.
`default_nettype none

module avg_pool_requant_u8_core #(
   parameter int IN_WIDTH  = apr_pkg::DefInWidth,
   parameter int IN_HEIGHT = apr_pkg::DefInHeight,
   parameter int CHANNELS  = apr_pkg::DefChannels,
   parameter int STRIDE_X  = apr_pkg::DefStrideX,
   parameter int STRIDE_Y  = apr_pkg::DefStrideY
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire apr_pkg::csr_index_type         csr_index,
   input  wire logic [apr_pkg::CsrDataW-1:0]   csr_data,
   apr_stream_if.sink                          req_if,
   apr_stream_if.source                        rsp_if
);

   localparam int Depth = IN_WIDTH * IN_HEIGHT * CHANNELS;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int YW    = $clog2(IN_HEIGHT + 1);
   localparam int XW    = $clog2(IN_WIDTH + 1);
   localparam int CW    = apr_pkg::CoordW;
   localparam int SumW  = apr_pkg::SumW;
   localparam int ProdW = apr_pkg::ProdW;
   localparam int DivW  = apr_pkg::DivW;
   localparam int DsrW  = apr_pkg::DsrW;
   localparam int ValW  = apr_pkg::ValW;

   localparam logic [AddrW-1:0] ColStep = AddrW'(CHANNELS);
   localparam logic [AddrW-1:0] RowPix  = AddrW'(IN_WIDTH);
   localparam logic [AddrW-1:0] RowStep = AddrW'(IN_WIDTH * CHANNELS);

   // configuration
   logic                     requant_ff, requant_in;
   logic signed [31:0]       scale_ff, scale_in;
   logic [5:0]               shift_ff, shift_in;
   logic signed [31:0]       offset_ff, offset_in;
   logic [4:0]               kw_ff, kw_in;
   logic [4:0]               kh_ff, kh_in;
   logic [3:0]               pad_top_ff, pad_top_in;
   logic [3:0]               pad_left_ff, pad_left_in;

   // control
   apr_pkg::state_type       state_ff, state_in;
   logic                     rd_take_ff, rd_take_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // item and datapath
   apr_pkg::op_type          op_ff, op_in;
   logic [4:0]               row_ff, row_in;
   logic [4:0]               col_ff, col_in;
   logic [3:0]               ch_ff, ch_in;
   logic [7:0]               pix_ff, pix_in;
   logic                     hit_ff, hit_in;
   logic [YW-1:0]            y_lo_ff, y_lo_in, y_hi_ff, y_hi_in, y_ff, y_in;
   logic [XW-1:0]            x_lo_ff, x_lo_in, x_hi_ff, x_hi_in, x_ff, x_in;
   logic [DsrW-1:0]          k_ff, k_in;
   logic [AddrW-1:0]         rowbase_ff, rowbase_in;
   logic [AddrW-1:0]         addr_ff, addr_in;
   logic [AddrW-1:0]         row_addr_ff, row_addr_in;
   logic [SumW-1:0]          sum_ff, sum_in;
   logic [7:0]               rd_data_ff;
   logic signed [ProdW-1:0]  prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic signed [ValW-1:0]   val_ff, val_in;
   logic [7:0]               rsp_value_ff, rsp_value_in;

   logic [7:0]               image_store [Depth];

   // combinational helpers
   logic [CW-1:0]            ry, rx;
   logic signed [CW-1:0]     ys, ye, xs, xe, y_start, x_start;
   logic [CW-1:0]            y_lo_c, y_hi_c, x_lo_c, x_hi_c;
   logic [DsrW-1:0]          k_prod;
   logic [AddrW-1:0]         pix_idx;
   logic [XW-1:0]            x_next;
   logic [YW-1:0]            y_next;
   logic signed [31:0]       scale_eff, offset_eff;
   logic signed [ProdW-1:0]  prod_abs;
   logic [5:0]               shift_eff;
   logic signed [ValW-1:0]   val_sh;
   logic [7:0]               byte_val;
   logic                     mem_we;
   logic                     div_start;
   logic [DivW-1:0]          div_dividend;
   logic [DivW-1:0]          div_quotient;
   apr_pkg::div_status_type  div_status;
   logic                     rsp_load;
   logic                     ch_ok;

   function automatic logic [CW-1:0] clip_to(input logic signed [CW-1:0] v,
                                             input logic [CW-1:0] hi);
      logic [CW-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if ($unsigned(v) > hi) begin
         r = hi;
      end else begin
         r = $unsigned(v);
      end
      return r;
   endfunction

   apr_div #(
      .DIVIDEND_W (DivW),
      .DIVISOR_W  (DsrW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (k_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // window placement
   assign ry      = CW'(row_ff) * CW'(STRIDE_Y);
   assign rx      = CW'(col_ff) * CW'(STRIDE_X);
   assign ys      = $signed(ry) - $signed(CW'(pad_top_ff));
   assign xs      = $signed(rx) - $signed(CW'(pad_left_ff));
   assign ye      = ys + $signed(CW'(kh_ff));
   assign xe      = xs + $signed(CW'(kw_ff));
   assign y_start = (op_ff == apr_pkg::OP_COMPUTE) ? ys : $signed(CW'(row_ff));
   assign x_start = (op_ff == apr_pkg::OP_COMPUTE) ? xs : $signed(CW'(col_ff));
   assign y_lo_c  = clip_to(y_start, CW'(IN_HEIGHT));
   assign y_hi_c  = clip_to(ye, CW'(IN_HEIGHT));
   assign x_lo_c  = clip_to(x_start, CW'(IN_WIDTH));
   assign x_hi_c  = clip_to(xe, CW'(IN_WIDTH));
   assign k_prod  = DsrW'(kw_ff) * DsrW'(kh_ff);
   assign ch_ok   = int'(ch_ff) < CHANNELS;

   assign pix_idx = rowbase_ff + AddrW'(x_lo_ff);
   assign x_next  = x_ff + XW'(1);
   assign y_next  = y_ff + YW'(1);

   assign scale_eff    = requant_ff ? scale_ff : 32'sd1;
   assign offset_eff   = requant_ff ? offset_ff : 32'sd0;
   assign shift_eff    = requant_ff ? shift_ff : 6'd0;
   assign prod_abs     = prod_ff[ProdW-1] ? -prod_ff : prod_ff;
   assign div_dividend = prod_abs[DivW-1:0];
   assign val_sh       = val_ff >>> shift_eff;

   always_comb begin
      if (val_sh < 0) begin
         byte_val = 8'd0;
      end else if (val_sh > apr_pkg::ByteMax) begin
         byte_val = 8'(apr_pkg::ByteMax);
      end else begin
         byte_val = val_sh[7:0];
      end
   end

   // configuration writes
   always_comb begin
      requant_in  = requant_ff;
      scale_in    = scale_ff;
      shift_in    = shift_ff;
      offset_in   = offset_ff;
      kw_in       = kw_ff;
      kh_in       = kh_ff;
      pad_top_in  = pad_top_ff;
      pad_left_in = pad_left_ff;
      if (csr_we) begin
         unique case (csr_index)
            apr_pkg::CSR_REQUANT_ENABLE: requant_in  = csr_data[0];
            apr_pkg::CSR_SCALE:          scale_in    = $signed(csr_data);
            apr_pkg::CSR_SHIFT:          shift_in    = csr_data[5:0];
            apr_pkg::CSR_OFFSET:         offset_in   = $signed(csr_data);
            apr_pkg::CSR_KERNEL_WIDTH:   kw_in       = csr_data[4:0];
            apr_pkg::CSR_KERNEL_HEIGHT:  kh_in       = csr_data[4:0];
            apr_pkg::CSR_PAD_TOP:        pad_top_in  = csr_data[3:0];
            apr_pkg::CSR_PAD_LEFT:       pad_left_in = csr_data[3:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      ch_in        = ch_ff;
      pix_in       = pix_ff;
      hit_in       = hit_ff;
      y_lo_in      = y_lo_ff;
      y_hi_in      = y_hi_ff;
      x_lo_in      = x_lo_ff;
      x_hi_in      = x_hi_ff;
      y_in         = y_ff;
      x_in         = x_ff;
      k_in         = k_ff;
      rowbase_in   = rowbase_ff;
      addr_in      = addr_ff;
      row_addr_in  = row_addr_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      val_in       = val_ff;
      rd_take_in   = 1'b0;
      mem_we       = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      req_if.ready = 1'b0;

      // fold in the byte read last cycle
      if (rd_take_ff) begin
         sum_in = sum_ff + SumW'(rd_data_ff);
      end

      unique case (state_ff)
         apr_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               op_in    = req_if.data.op;
               row_in   = req_if.data.row;
               col_in   = req_if.data.col;
               ch_in    = req_if.data.channel;
               pix_in   = req_if.data.pixel;
               state_in = apr_pkg::ST_SETUP;
            end
         end
         apr_pkg::ST_SETUP: begin
            y_lo_in  = y_lo_c[YW-1:0];
            y_hi_in  = y_hi_c[YW-1:0];
            x_lo_in  = x_lo_c[XW-1:0];
            x_hi_in  = x_hi_c[XW-1:0];
            k_in     = (k_prod == '0) ? DsrW'(1) : k_prod;
            sum_in   = '0;
            if (op_ff == apr_pkg::OP_LOAD) begin
               hit_in = ch_ok && (int'(row_ff) < IN_HEIGHT) && (int'(col_ff) < IN_WIDTH);
            end else begin
               hit_in = ch_ok;
            end
            state_in = apr_pkg::ST_BASE;
         end
         apr_pkg::ST_BASE: begin
            rowbase_in = AddrW'(y_lo_ff) * RowPix;
            state_in   = apr_pkg::ST_ADDR;
         end
         apr_pkg::ST_ADDR: begin
            addr_in     = pix_idx * ColStep + AddrW'(ch_ff);
            row_addr_in = pix_idx * ColStep + AddrW'(ch_ff);
            x_in        = x_lo_ff;
            y_in        = y_lo_ff;
            if (op_ff == apr_pkg::OP_LOAD) begin
               state_in = apr_pkg::ST_WRITE;
            end else if (!hit_ff || (y_lo_ff >= y_hi_ff) || (x_lo_ff >= x_hi_ff)) begin
               // nothing of the window lies in the image, or the channel is out of range: sum stays zero
               state_in = apr_pkg::ST_MUL;
            end else begin
               state_in = apr_pkg::ST_SCAN;
            end
         end
         apr_pkg::ST_WRITE: begin
            mem_we   = hit_ff;
            state_in = apr_pkg::ST_FINISH;
         end
         apr_pkg::ST_SCAN: begin
            rd_take_in = 1'b1;
            if (x_next == x_hi_ff) begin
               if (y_next == y_hi_ff) begin
                  state_in = apr_pkg::ST_DRAIN;
               end else begin
                  y_in        = y_next;
                  x_in        = x_lo_ff;
                  row_addr_in = row_addr_ff + RowStep;
                  addr_in     = row_addr_ff + RowStep;
               end
            end else begin
               x_in    = x_next;
               addr_in = addr_ff + ColStep;
            end
         end
         apr_pkg::ST_DRAIN: begin
            state_in = apr_pkg::ST_MUL;
         end
         apr_pkg::ST_MUL: begin
            prod_in  = $signed({1'b0, sum_ff}) * scale_eff;
            state_in = apr_pkg::ST_DIV_GO;
         end
         apr_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            neg_in    = prod_ff[ProdW-1];
            state_in  = apr_pkg::ST_DIV;
         end
         apr_pkg::ST_DIV: begin
            if (div_status.done) begin
               // restore the sign of the truncated quotient while adding the offset
               if (neg_ff) begin
                  val_in = ValW'(offset_eff) - $signed(ValW'(div_quotient));
               end else begin
                  val_in = ValW'(offset_eff) + $signed(ValW'(div_quotient));
               end
               state_in = apr_pkg::ST_FINISH;
            end
         end
         apr_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = apr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = apr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = (op_ff == apr_pkg::OP_LOAD) ? 8'd0 : byte_val;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apr_pkg::ST_IDLE;
         rd_take_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         requant_ff   <= 1'b0;
         scale_ff     <= 32'sd1;
         shift_ff     <= 6'd0;
         offset_ff    <= 32'sd0;
         kw_ff        <= 5'd2;
         kh_ff        <= 5'd2;
         pad_top_ff   <= 4'd0;
         pad_left_ff  <= 4'd0;
      end else begin
         state_ff     <= state_in;
         rd_take_ff   <= rd_take_in;
         rsp_valid_ff <= rsp_valid_in;
         requant_ff   <= requant_in;
         scale_ff     <= scale_in;
         shift_ff     <= shift_in;
         offset_ff    <= offset_in;
         kw_ff        <= kw_in;
         kh_ff        <= kh_in;
         pad_top_ff   <= pad_top_in;
         pad_left_ff  <= pad_left_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      ch_ff        <= ch_in;
      pix_ff       <= pix_in;
      hit_ff       <= hit_in;
      y_lo_ff      <= y_lo_in;
      y_hi_ff      <= y_hi_in;
      x_lo_ff      <= x_lo_in;
      x_hi_ff      <= x_hi_in;
      y_ff         <= y_in;
      x_ff         <= x_in;
      k_ff         <= k_in;
      rowbase_ff   <= rowbase_in;
      addr_ff      <= addr_in;
      row_addr_ff  <= row_addr_in;
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      val_ff       <= val_in;
      rsp_value_ff <= rsp_value_in;
   end

   // image store: one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         image_store[addr_ff] <= pix_ff;
      end
      rd_data_ff <= image_store[addr_ff];
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.data.result_value = rsp_value_ff;

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == apr_pkg::ST_MUL |-> int'(sum_ff) <= apr_pkg::ByteMax * int'(k_ff))
      else $error("window sum exceeds byte limit times divisor");

   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == apr_pkg::ST_SCAN |->
         (x_ff >= x_lo_ff) && (x_ff < x_hi_ff) && (y_ff >= y_lo_ff) && (y_ff < y_hi_ff))
      else $error("scan position left the clipped window");

   a_scan_addr: assert property (@(posedge clock) disable iff (reset)
      state_ff == apr_pkg::ST_SCAN |-> int'(addr_ff) < Depth)
      else $error("scan address beyond image store");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == apr_pkg::ST_DIV)
      else $error("divider finished outside the wait state");

   a_load_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (op_ff == apr_pkg::OP_LOAD) |=> rsp_value_ff == 8'd0)
      else $error("load word produced a nonzero result");

endmodule

`default_nettype wire
